FILE: rtl/core/crrd_pkg.sv
`timescale 1ns / 1ps

package crrd_pkg;

	localparam int SLOTS    = 8;
	localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int HANDLE_W = 16;

	localparam logic OP_INSERT     = 1'b0;
	localparam logic KIND_PERIODIC = 1'b1;

	localparam logic [1:0] EMIT_STATUS   = 2'd0;
	localparam logic [1:0] EMIT_EMPTY    = 2'd1;
	localparam logic [1:0] EMIT_CYCLIC   = 2'd2;
	localparam logic [1:0] EMIT_PERIODIC = 2'd3;

	typedef struct packed {
		logic       capture;
		logic       insert;
		logic       walk_start;
		logic       walk_next;
		logic       note_slot;
		logic       emit;
		logic [1:0] emit_sel;
		logic       cursor_adv;
	} ctl_cmd_t;

	typedef struct packed {
		logic op;
		logic tbl_full;
		logic tbl_empty;
		logic slot_periodic;
		logic walk_end;
		logic periodic_any;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: rtl/core/crrd_req_if.sv
`timescale 1ns / 1ps

interface crrd_req_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic                          routine_kind;
	logic [crrd_pkg::HANDLE_W-1:0] routine_handle;

	modport source (
		output valid, operation, routine_kind, routine_handle,
		input  ready
	);

	modport sink (
		input  valid, operation, routine_kind, routine_handle,
		output ready
	);
endinterface

FILE: rtl/core/crrd_rsp_if.sv
`timescale 1ns / 1ps

interface crrd_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [crrd_pkg::HANDLE_W-1:0] handle_out;
	logic                          handle_valid;
	logic                          kind_out;
	logic                          status;
	logic                          last;

	modport source (
		output valid, handle_out, handle_valid, kind_out, status, last,
		input  ready
	);

	modport sink (
		input  valid, handle_out, handle_valid, kind_out, status, last,
		output ready
	);
endinterface

FILE: rtl/core/crrd_datapath.sv
`timescale 1ns / 1ps

module crrd_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  crrd_pkg::ctl_cmd_t            cmd,
	output crrd_pkg::dp_sts_t             sts,
	input  logic                          req_operation,
	input  logic                          req_routine_kind,
	input  logic [crrd_pkg::HANDLE_W-1:0] req_routine_handle,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [crrd_pkg::HANDLE_W-1:0] rsp_handle_out,
	output logic                          rsp_handle_valid,
	output logic                          rsp_kind_out,
	output logic                          rsp_status,
	output logic                          rsp_last
);

	logic                          op_q;
	logic                          kind_q;
	logic [crrd_pkg::HANDLE_W-1:0] handle_q;

	logic [crrd_pkg::HANDLE_W-1:0] slot_handle_q [crrd_pkg::SLOTS];
	logic                          slot_per_q    [crrd_pkg::SLOTS];
	logic [crrd_pkg::HANDLE_W-1:0] rd_handle_s1;
	logic                          rd_per_s1;

	logic [crrd_pkg::CNT_W-1:0]    used_q;
	logic [crrd_pkg::CNT_W-1:0]    pcount_q;
	logic [crrd_pkg::IDX_W-1:0]    cursor_q;
	logic [crrd_pkg::IDX_W-1:0]    idx_q;
	logic [crrd_pkg::CNT_W-1:0]    per_seen_q;
	logic [crrd_pkg::HANDLE_W-1:0] per_handle_q;

	logic                          rsp_valid_q;
	logic [crrd_pkg::HANDLE_W-1:0] rsp_handle_q;
	logic                          rsp_hvalid_q;
	logic                          rsp_kind_q;
	logic                          rsp_status_q;
	logic                          rsp_last_q;

	logic                          tbl_full;
	logic                          walk_end;
	logic [crrd_pkg::IDX_W-1:0]    cur_eff;
	logic [crrd_pkg::CNT_W-1:0]    cur_next_ext;
	logic [crrd_pkg::IDX_W-1:0]    cur_next;
	logic                          cyc_last;

	assign tbl_full     = used_q >= crrd_pkg::CNT_W'(crrd_pkg::SLOTS);
	assign walk_end     = (crrd_pkg::CNT_W'(idx_q) + crrd_pkg::CNT_W'(1)) == used_q;
	assign cur_eff      = (crrd_pkg::CNT_W'(cursor_q) >= pcount_q) ? '0 : cursor_q;
	assign cur_next_ext = crrd_pkg::CNT_W'(cur_eff) + crrd_pkg::CNT_W'(1);
	assign cur_next     = (cur_next_ext >= pcount_q) ? '0 : cur_next_ext[crrd_pkg::IDX_W-1:0];
	assign cyc_last     = (pcount_q == '0) && walk_end;

	always_comb begin
		sts.op            = op_q;
		sts.tbl_full      = tbl_full;
		sts.tbl_empty     = (used_q == '0);
		sts.slot_periodic = rd_per_s1;
		sts.walk_end      = walk_end;
		sts.periodic_any  = (pcount_q != '0);
		sts.out_free      = !rsp_valid_q || rsp_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= req_operation;
			kind_q   <= req_routine_kind;
			handle_q <= req_routine_handle;
		end
	end

	// slot store, registered read at the walk index
	always_ff @(posedge clk) begin
		if (cmd.insert && !tbl_full) begin
			slot_handle_q[used_q[crrd_pkg::IDX_W-1:0]] <= handle_q;
			slot_per_q[used_q[crrd_pkg::IDX_W-1:0]]    <= kind_q;
		end
		rd_handle_s1 <= slot_handle_q[idx_q];
		rd_per_s1    <= slot_per_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			pcount_q   <= '0;
			cursor_q   <= '0;
			idx_q      <= '0;
			per_seen_q <= '0;
		end else begin
			if (cmd.insert && !tbl_full) begin
				used_q <= used_q + crrd_pkg::CNT_W'(1);
				if (kind_q == crrd_pkg::KIND_PERIODIC) begin
					pcount_q <= pcount_q + crrd_pkg::CNT_W'(1);
				end
			end
			if (cmd.walk_start) begin
				idx_q      <= '0;
				per_seen_q <= '0;
			end else begin
				if (cmd.walk_next) begin
					idx_q <= idx_q + crrd_pkg::IDX_W'(1);
				end
				if (cmd.note_slot && rd_per_s1 == crrd_pkg::KIND_PERIODIC) begin
					per_seen_q <= per_seen_q + crrd_pkg::CNT_W'(1);
				end
			end
			if (cmd.cursor_adv) begin
				cursor_q <= cur_next;
			end
		end
	end

	// pick the periodic routine at the cursor
	always_ff @(posedge clk) begin
		if (cmd.note_slot && rd_per_s1 == crrd_pkg::KIND_PERIODIC
			&& per_seen_q == crrd_pkg::CNT_W'(cur_eff)) begin
			per_handle_q <= rd_handle_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.emit_sel)
				crrd_pkg::EMIT_STATUS: begin
					rsp_handle_q <= '0;
					rsp_hvalid_q <= 1'b0;
					rsp_kind_q   <= 1'b0;
					rsp_status_q <= tbl_full;
					rsp_last_q   <= 1'b1;
				end
				crrd_pkg::EMIT_CYCLIC: begin
					rsp_handle_q <= rd_handle_s1;
					rsp_hvalid_q <= 1'b1;
					rsp_kind_q   <= 1'b0;
					rsp_status_q <= 1'b0;
					rsp_last_q   <= cyc_last;
				end
				crrd_pkg::EMIT_PERIODIC: begin
					rsp_handle_q <= per_handle_q;
					rsp_hvalid_q <= 1'b1;
					rsp_kind_q   <= 1'b1;
					rsp_status_q <= 1'b0;
					rsp_last_q   <= 1'b1;
				end
				default: begin
					rsp_handle_q <= '0;
					rsp_hvalid_q <= 1'b0;
					rsp_kind_q   <= 1'b0;
					rsp_status_q <= 1'b0;
					rsp_last_q   <= 1'b1;
				end
			endcase
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign rsp_handle_out   = rsp_handle_q;
	assign rsp_handle_valid = rsp_hvalid_q;
	assign rsp_kind_out     = rsp_kind_q;
	assign rsp_status       = rsp_status_q;
	assign rsp_last         = rsp_last_q;

endmodule

FILE: rtl/core/crrd_ctrl.sv
`timescale 1ns / 1ps

module crrd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  crrd_pkg::dp_sts_t    sts,
	output crrd_pkg::ctl_cmd_t   cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DEC  = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_EV   = 3'd3;
	localparam logic [2:0] ST_PER  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.emit_sel   = crrd_pkg::EMIT_STATUS;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DEC;
				end
			end
			ST_DEC: begin
				if (sts.op == crrd_pkg::OP_INSERT) begin
					if (sts.out_free) begin
						cmd.insert   = 1'b1;
						cmd.emit     = 1'b1;
						cmd.emit_sel = crrd_pkg::EMIT_STATUS;
						state_d      = ST_IDLE;
					end
				end else if (sts.tbl_empty) begin
					if (sts.out_free) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = crrd_pkg::EMIT_EMPTY;
						state_d      = ST_IDLE;
					end
				end else begin
					cmd.walk_start = 1'b1;
					state_d        = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_EV;
			end
			ST_EV: begin
				if (sts.slot_periodic || sts.out_free) begin
					cmd.note_slot = 1'b1;
					if (!sts.slot_periodic) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = crrd_pkg::EMIT_CYCLIC;
					end
					if (sts.walk_end) begin
						state_d = sts.periodic_any ? ST_PER : ST_IDLE;
					end else begin
						cmd.walk_next = 1'b1;
						state_d       = ST_RD;
					end
				end
			end
			ST_PER: begin
				if (sts.out_free) begin
					cmd.emit       = 1'b1;
					cmd.emit_sel   = crrd_pkg::EMIT_PERIODIC;
					cmd.cursor_adv = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/core/cyclic_round_robin_dispatcher.sv
`timescale 1ns / 1ps

// Cyclic round-robin dispatcher over a table of crrd_pkg::SLOTS routine slots.
// req carries one transaction per operation: an insert registers routine_handle
// as cyclic or periodic in the next free slot; a run tick asks for dispatch.
// rsp returns one transaction per insert (status 1 when the table is full and
// the routine is dropped) and, per tick, every cyclic handle in insertion order
// and one periodic handle picked round-robin, if any; last marks the final one.
// A tick with an empty table returns a single transaction with handle_valid 0.
// An insert or empty tick is answered from the decode state after accept. A tick
// walks the slot store through its single registered read port: per filled slot
// a read state waits on the read and an evaluate state emits or notes the slot;
// a periodic state then emits the periodic result, if any. One operation is
// worked at a time; req.ready is high again once the last result is loaded.
// Reset clears the table, the periodic cursor and all pending results.
// The result sits in an output register; when rsp.ready is low the walk holds
// before the next emission, so a stall only delays the sequence.
module cyclic_round_robin_dispatcher (
	input logic        clk,
	input logic        arst_n,
	crrd_req_if.sink   req,
	crrd_rsp_if.source rsp
);

	crrd_pkg::ctl_cmd_t cmd;
	crrd_pkg::dp_sts_t  sts;

	crrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	crrd_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.req_operation      (req.operation),
		.req_routine_kind   (req.routine_kind),
		.req_routine_handle (req.routine_handle),
		.rsp_valid          (rsp.valid),
		.rsp_ready          (rsp.ready),
		.rsp_handle_out     (rsp.handle_out),
		.rsp_handle_valid   (rsp.handle_valid),
		.rsp_kind_out       (rsp.kind_out),
		.rsp_status         (rsp.status),
		.rsp_last           (rsp.last)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded over a pending transaction");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while an operation is in work");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_start |-> !sts.tbl_empty)
		else $error("slot walk started on an empty table");

	a_periodic_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.emit_sel == crrd_pkg::EMIT_PERIODIC |=> rsp.valid && rsp.last)
		else $error("periodic result not marked last");

endmodule

FILE: bench/tb_cyclic_round_robin_dispatcher.sv
`timescale 1ns / 1ps

module tb_cyclic_round_robin_dispatcher;

	localparam logic OP_TICK      = ~crrd_pkg::OP_INSERT;
	localparam logic KIND_CYCLIC  = ~crrd_pkg::KIND_PERIODIC;
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_FULL  = 1'b1;
	localparam int   RANDOM_ITEMS = 410;
	localparam int   LONG_HOLD    = 200;
	localparam int   DRAIN_CYCLES = 25;
	localparam int   IDLE_LIMIT   = 3000;

	typedef struct packed {
		logic [crrd_pkg::HANDLE_W-1:0] handle;
		logic                          handle_valid;
		logic                          kind;
		logic                          status;
		logic                          last;
	} dispatch_t;

	typedef struct packed {
		logic                          op;
		logic                          kind;
		logic [crrd_pkg::HANDLE_W-1:0] handle;
		logic                          typed;
		dispatch_t                     result;
	} request_t;

	logic clk;
	logic arst_n;

	crrd_req_if req_ch ();
	crrd_rsp_if rsp_ch ();

	cyclic_round_robin_dispatcher uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	logic [crrd_pkg::HANDLE_W-1:0] slot_handles [crrd_pkg::SLOTS];
	logic                          slot_periodic [crrd_pkg::SLOTS];
	int unsigned                   slots_filled;
	int unsigned                   rr_cursor;
	int unsigned                   periodic_slots;

	dispatch_t pending_dispatch [$];
	dispatch_t predicted_batch [$];
	request_t  directed_rows [$];

	int  mismatches;
	int  requests_sent;
	int  ticks_sent;
	int  inserts_sent;
	int  inserts_dropped;
	int  results_checked;
	int  longest_tick;
	int  idle_cycles;
	bit  req_calm;
	bit  rsp_calm;
	bit  hold_output;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic request_t plain_row(logic op, logic kind,
			logic [crrd_pkg::HANDLE_W-1:0] h);
		request_t r;
		r        = '0;
		r.op     = op;
		r.kind   = kind;
		r.handle = h;
		return r;
	endfunction

	function automatic request_t typed_row(logic op, logic kind,
			logic [crrd_pkg::HANDLE_W-1:0] h, logic st);
		request_t r;
		r               = plain_row(op, kind, h);
		r.typed         = 1'b1;
		r.result.status = st;
		r.result.last   = 1'b1;
		return r;
	endfunction

	function automatic void predict_dispatch(logic op, logic kind,
			logic [crrd_pkg::HANDLE_W-1:0] h);
		dispatch_t   r;
		int unsigned seen;
		predicted_batch.delete();
		r      = '0;
		r.last = 1'b1;
		if (op == crrd_pkg::OP_INSERT) begin
			if (slots_filled >= crrd_pkg::SLOTS) begin
				r.status = STATUS_FULL;
			end else begin
				slot_handles[slots_filled]  = h;
				slot_periodic[slots_filled] = kind;
				slots_filled++;
				if (kind == crrd_pkg::KIND_PERIODIC)
					periodic_slots++;
			end
			predicted_batch.push_back(r);
			return;
		end
		if (slots_filled == 0) begin
			predicted_batch.push_back(r);
			return;
		end
		r.last         = 1'b0;
		r.handle_valid = 1'b1;
		for (int i = 0; i < slots_filled; i++) begin
			if (slot_periodic[i] == KIND_CYCLIC) begin
				r.handle = slot_handles[i];
				r.kind   = KIND_CYCLIC;
				predicted_batch.push_back(r);
			end
		end
		if (periodic_slots != 0) begin
			if (rr_cursor >= periodic_slots)
				rr_cursor = 0;
			seen = 0;
			for (int i = 0; i < slots_filled; i++) begin
				if (slot_periodic[i] == crrd_pkg::KIND_PERIODIC) begin
					if (seen == rr_cursor) begin
						r.handle = slot_handles[i];
						r.kind   = crrd_pkg::KIND_PERIODIC;
						predicted_batch.push_back(r);
						break;
					end
					seen++;
				end
			end
			rr_cursor++;
			if (rr_cursor >= periodic_slots)
				rr_cursor = 0;
		end
		r      = predicted_batch.pop_back();
		r.last = 1'b1;
		predicted_batch.push_back(r);
	endfunction

	task automatic report_mismatch(string what, logic [crrd_pkg::HANDLE_W-1:0] got,
			logic [crrd_pkg::HANDLE_W-1:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t ns", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic push_request(request_t item);
		int unsigned gap;
		req_ch.valid          <= 1'b1;
		req_ch.operation      <= item.op;
		req_ch.routine_kind   <= item.kind;
		req_ch.routine_handle <= item.handle;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predict_dispatch(item.op, item.kind, item.handle);
		requests_sent++;
		if (item.op == crrd_pkg::OP_INSERT) begin
			inserts_sent++;
			if (predicted_batch[0].status == STATUS_FULL)
				inserts_dropped++;
		end else begin
			ticks_sent++;
			if (predicted_batch.size() > longest_tick)
				longest_tick = predicted_batch.size();
		end
		if (item.typed)
			pending_dispatch.push_back(item.result);
		else
			foreach (predicted_batch[i])
				pending_dispatch.push_back(predicted_batch[i]);
		gap = req_calm ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int unsigned stall;
		dispatch_t   want;
		dispatch_t   got;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_output) begin
				hold_output = 1'b0;
				stall       = LONG_HOLD;
			end else if (rsp_calm) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 6);
			end
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			got = {rsp_ch.handle_out, rsp_ch.handle_valid, rsp_ch.kind_out,
				rsp_ch.status, rsp_ch.last};
			results_checked++;
			if (results_checked % 37 == 0)
				rsp_calm = ($urandom_range(0, 2) == 0);
			if (pending_dispatch.size() == 0) begin
				report_mismatch("result with nothing pending", got.handle, '0);
			end else begin
				want = pending_dispatch.pop_front();
				if (got.handle !== want.handle)
					report_mismatch("handle_out", got.handle, want.handle);
				if (got.handle_valid !== want.handle_valid)
					report_mismatch("handle_valid", got.handle_valid, want.handle_valid);
				if (got.kind !== want.kind)
					report_mismatch("kind_out", got.kind, want.kind);
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.last !== want.last)
					report_mismatch("last", got.last, want.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout after %0d idle cycles", idle_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		request_t item;
		arst_n                <= 1'b0;
		req_ch.valid          <= 1'b0;
		req_ch.operation      <= crrd_pkg::OP_INSERT;
		req_ch.routine_kind   <= KIND_CYCLIC;
		req_ch.routine_handle <= '0;
		slots_filled   = 0;
		rr_cursor      = 0;
		periodic_slots = 0;
		idle_cycles    = 0;

		directed_rows = '{
			typed_row(OP_TICK,             KIND_CYCLIC,             16'h0000, STATUS_OK),
			typed_row(crrd_pkg::OP_INSERT, crrd_pkg::KIND_PERIODIC, 16'hFFFF, STATUS_OK),
			plain_row(OP_TICK,             KIND_CYCLIC,             16'h0000),
			plain_row(OP_TICK,             crrd_pkg::KIND_PERIODIC, 16'hFFFF),
			typed_row(crrd_pkg::OP_INSERT, KIND_CYCLIC,             16'h0000, STATUS_OK),
			plain_row(OP_TICK,             KIND_CYCLIC,             16'h0000),
			plain_row(crrd_pkg::OP_INSERT, crrd_pkg::KIND_PERIODIC, 16'($urandom)),
			plain_row(OP_TICK,             KIND_CYCLIC,             16'h0000),
			plain_row(crrd_pkg::OP_INSERT, crrd_pkg::KIND_PERIODIC, 16'hAAAA),
			plain_row(OP_TICK,             KIND_CYCLIC,             16'hFFFF),
			plain_row(OP_TICK,             crrd_pkg::KIND_PERIODIC, 16'h0000),
			plain_row(OP_TICK,             KIND_CYCLIC,             16'h0000),
			plain_row(crrd_pkg::OP_INSERT, KIND_CYCLIC,             16'h5555),
			plain_row(crrd_pkg::OP_INSERT, KIND_CYCLIC,             16'($urandom)),
			plain_row(OP_TICK,             KIND_CYCLIC,             16'h0000),
			plain_row(crrd_pkg::OP_INSERT, crrd_pkg::KIND_PERIODIC, 16'($urandom)),
			plain_row(crrd_pkg::OP_INSERT, KIND_CYCLIC,             16'($urandom)),
			typed_row(crrd_pkg::OP_INSERT, crrd_pkg::KIND_PERIODIC, 16'h8001, STATUS_FULL),
			plain_row(OP_TICK,             KIND_CYCLIC,             16'h0000),
			typed_row(crrd_pkg::OP_INSERT, KIND_CYCLIC,             16'h7FFE, STATUS_FULL),
			plain_row(OP_TICK,             crrd_pkg::KIND_PERIODIC, 16'hFFFF),
			plain_row(OP_TICK,             KIND_CYCLIC,             16'h0000),
			plain_row(OP_TICK,             KIND_CYCLIC,             16'h0000)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			push_request(directed_rows[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 45 == 0)
				req_calm = ($urandom_range(0, 2) == 0);
			if (n == 60) begin
				req_calm    = 1'b1;
				hold_output = 1'b1;
			end
			item = plain_row(($urandom_range(0, 3) == 0) ? crrd_pkg::OP_INSERT : OP_TICK,
				1'($urandom), 16'($urandom));
			push_request(item);
		end
		req_ch.valid <= 1'b0;

		while (pending_dispatch.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_dispatch.size() != 0)
			report_mismatch("results never delivered",
				crrd_pkg::HANDLE_W'(pending_dispatch.size()), '0);

		$display("Covered %0d requests: %0d run ticks, %0d inserts (%0d dropped on a full table)",
			requests_sent, ticks_sent, inserts_sent, inserts_dropped);
		$display("Checked %0d dispatch results, up to %0d per tick, across a %0d-cycle output stall",
			results_checked, longest_tick, LONG_HOLD);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
